FILE: design/team_grouped_fifo_macros.svh
// ----------------------------------------------------------------------------
// Team grouped FIFO assertion macros
// Concurrent assertion forms used by the team queue back end.
// ----------------------------------------------------------------------------
`ifndef TEAM_GROUPED_FIFO_MACROS_SVH
`define TEAM_GROUPED_FIFO_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TGF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/tgf_pkg.sv
// ----------------------------------------------------------------------------
// Team grouped FIFO package
// Word types, operation and status codes, and the id reduction helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgf_pkg;

	localparam int ID_W     = 10;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	localparam int NUM_ELEMENTS_DEF = 1024;
	localparam int NUM_TEAMS_DEF    = 1024;
	localparam int POOL_DEPTH_DEF   = 1024;

	// Depth of the command queue between front and back, a power of two.
	localparam int CMD_DEPTH = 2;

	localparam logic [OP_W-1:0] OP_ASSIGN  = 2'd0;
	localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd1;
	localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		logic [ID_W-1:0] element_id;
		logic [ID_W-1:0] team_id;
	} in_word_t;

	typedef struct packed {
		logic [ID_W-1:0]     element_out;
		logic [STATUS_W-1:0] status;
	} out_word_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [ID_W-1:0] elem;
		logic [ID_W-1:0] team;
	} cmd_t;

	// Remainder of an id by a fixed modulus, by shifted compare and subtract.
	// Only the steps whose shifted modulus fits the id width do any work.
	function automatic logic [ID_W-1:0] id_reduce(input logic [ID_W-1:0] v,
		input int unsigned modulus);
		logic [ID_W:0] rem;
		int unsigned   step;
		rem = {1'b0, v};
		for (int k = ID_W - 1; k >= 0; k--) begin
			step = modulus << k;
			if (step < (32'd1 << ID_W) && {{(31 - ID_W){1'b0}}, rem} >= step) begin
				rem = rem - step[ID_W:0];
			end
		end
		return rem[ID_W-1:0];
	endfunction

endpackage

FILE: design/tgf_front.sv
// ----------------------------------------------------------------------------
// Team grouped FIFO front end
// Accepts words, keeps the membership table, and turns enqueue, dequeue
// and clear words into team-tagged commands for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgf_front
	import tgf_pkg::*;
#(
	parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF,
	parameter int NUM_TEAMS    = NUM_TEAMS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  in_word_t req,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output cmd_t     cmd
);

	localparam int EW = $clog2(NUM_ELEMENTS);

	logic [ID_W-1:0] member_mem [NUM_ELEMENTS];

	logic            wiping_q;
	logic [EW-1:0]   wipe_idx_q;
	logic            valid_s1;
	logic [OP_W-1:0] op_s1;
	logic [ID_W-1:0] elem_s1;
	logic [ID_W-1:0] team_s1;

	logic            req_fire;
	logic [ID_W-1:0] elem_red;
	logic [ID_W-1:0] team_red;
	logic [EW-1:0]   elem_idx;

	// Ids wrap into the configured element and team ranges.
	assign elem_red = id_reduce(req.element_id, NUM_ELEMENTS);
	assign team_red = id_reduce(req.team_id, NUM_TEAMS);
	assign elem_idx = EW'(elem_red);

	assign req_ready = !wiping_q && (!valid_s1 || cmd_ready);
	assign req_fire  = req_valid && req_ready;

	// After reset the membership table is swept to team zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiping_q   <= 1'b1;
			wipe_idx_q <= '0;
		end else if (wiping_q) begin
			wipe_idx_q <= wipe_idx_q + EW'(1);
			if (wipe_idx_q == EW'(NUM_ELEMENTS - 1)) begin
				wiping_q <= 1'b0;
			end
		end
	end

	// Membership table: assign writes, all other words read the team.
	always_ff @(posedge clk) begin
		if (wiping_q) begin
			member_mem[wipe_idx_q] <= '0;
		end else if (req_fire && req.operation == OP_ASSIGN) begin
			member_mem[elem_idx] <= team_red;
		end else if (req_fire) begin
			team_s1 <= member_mem[elem_idx];
		end
	end

	// Command stage; assign words finish here and pass nothing on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_fire) begin
			valid_s1 <= (req.operation != OP_ASSIGN);
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_s1   <= req.operation;
			elem_s1 <= elem_red;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd.op    = op_s1;
	assign cmd.elem  = elem_s1;
	assign cmd.team  = team_s1;

endmodule

FILE: design/tgf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Team grouped FIFO command queue
// Short queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgf_cmd_fifo
	import tgf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output cmd_t rd_data
);

	localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;

	cmd_t             data_q [CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != (PTR_W + 1)'(CMD_DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = data_q[rd_ptr_q];

	// Pointers wrap naturally since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: design/tgf_back.sv
// ----------------------------------------------------------------------------
// Team grouped FIFO back end
// Runs enqueue, dequeue and clear on the linked pool, the per-team head
// and tail table and the team order queue, and holds the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "team_grouped_fifo_macros.svh"

module tgf_back
	import tgf_pkg::*;
#(
	parameter int NUM_TEAMS  = NUM_TEAMS_DEF,
	parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_word_t rsp
);

	localparam int TW     = (NUM_TEAMS > 1) ? $clog2(NUM_TEAMS) : 1;
	localparam int PW     = $clog2(POOL_DEPTH);
	localparam int TEAM_W = 1 + 2 * PW;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ENQ   = 3'd1;
	localparam logic [2:0] S_DEQ_T = 3'd2;
	localparam logic [2:0] S_DEQ_E = 3'd3;
	localparam logic [2:0] S_DEQ_W = 3'd4;
	localparam logic [2:0] S_WIPE  = 3'd5;

	// Memories: pool values, pool links, free stack, team words, team order.
	logic [ID_W-1:0]   val_mem  [POOL_DEPTH];
	logic [PW-1:0]     nxt_mem  [POOL_DEPTH];
	logic [PW-1:0]     stk_mem  [POOL_DEPTH];
	logic [TEAM_W-1:0] team_mem [NUM_TEAMS];
	logic [ID_W-1:0]   ord_mem  [NUM_TEAMS];

	logic [2:0]        state_q;
	logic [PW:0]       fresh_q;
	logic [PW:0]       stk_cnt_q;
	logic [TW-1:0]     rp_q;
	logic [TW-1:0]     wp_q;
	logic [TW:0]       ord_cnt_q;
	logic [TW-1:0]     wipe_idx_q;
	logic              rsp_valid_q;
	out_word_t         rsp_q;
	logic [ID_W-1:0]   elem_q;
	logic [ID_W-1:0]   team_q;
	logic              use_stk_q;
	logic [PW-1:0]     slot_q;
	logic [PW-1:0]     stk_rd_q;
	logic [TEAM_W-1:0] team_rd_q;
	logic [ID_W-1:0]   ord_rd_q;
	logic [ID_W-1:0]   val_rd_q;
	logic [PW-1:0]     nxt_rd_q;

	logic              pop;
	logic              pool_empty;
	logic              rsp_set;
	logic [PW-1:0]     slot;
	logic              waiting;
	logic [PW-1:0]     head;
	logic [PW-1:0]     tail;
	logic [TW-1:0]     team_addr;
	logic [TW-1:0]     rp_next;

	assign cmd_ready  = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign pop        = cmd_valid && cmd_ready;
	assign pool_empty = (stk_cnt_q == '0) && (fresh_q == (PW + 1)'(POOL_DEPTH));
	assign slot       = use_stk_q ? stk_rd_q : slot_q;
	assign waiting    = team_rd_q[TEAM_W-1];
	assign head       = team_rd_q[2*PW-1:PW];
	assign tail       = team_rd_q[PW-1:0];
	assign rp_next    = (rp_q == TW'(NUM_TEAMS - 1)) ? '0 : rp_q + TW'(1);

	// A result is raised by a full enqueue, an empty dequeue or a finished dequeue.
	assign rsp_set = (pop && cmd.op == OP_ENQUEUE && pool_empty)
		|| (pop && cmd.op == OP_DEQUEUE && ord_cnt_q == '0)
		|| (state_q == S_DEQ_W);

	// Team table address for each step.
	always_comb begin
		unique case (state_q)
			S_IDLE:  team_addr = TW'(cmd.team);
			S_DEQ_T: team_addr = TW'(ord_rd_q);
			S_WIPE:  team_addr = wipe_idx_q;
			default: team_addr = TW'(team_q);
		endcase
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_set) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Control sequencer and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_WIPE;
			fresh_q     <= '0;
			stk_cnt_q   <= '0;
			rp_q        <= '0;
			wp_q        <= '0;
			ord_cnt_q   <= '0;
			wipe_idx_q  <= '0;
			use_stk_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						unique case (cmd.op)
							OP_CLEAR: begin
								fresh_q    <= '0;
								stk_cnt_q  <= '0;
								rp_q       <= '0;
								wp_q       <= '0;
								ord_cnt_q  <= '0;
								wipe_idx_q <= '0;
								state_q    <= S_WIPE;
							end
							OP_ENQUEUE: begin
								if (!pool_empty && stk_cnt_q != '0) begin
									stk_cnt_q <= stk_cnt_q - (PW + 1)'(1);
									use_stk_q <= 1'b1;
									state_q   <= S_ENQ;
								end else if (!pool_empty) begin
									fresh_q   <= fresh_q + (PW + 1)'(1);
									use_stk_q <= 1'b0;
									state_q   <= S_ENQ;
								end
							end
							OP_DEQUEUE: begin
								if (ord_cnt_q != '0) begin
									state_q <= S_DEQ_T;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_ENQ: begin
					if (!waiting && ord_cnt_q < (TW + 1)'(NUM_TEAMS)) begin
						wp_q      <= (wp_q == TW'(NUM_TEAMS - 1)) ? '0 : wp_q + TW'(1);
						ord_cnt_q <= ord_cnt_q + (TW + 1)'(1);
					end
					state_q <= S_IDLE;
				end
				S_DEQ_T: begin
					state_q <= S_DEQ_E;
				end
				S_DEQ_E: begin
					state_q <= S_DEQ_W;
				end
				S_DEQ_W: begin
					if (head == tail) begin
						rp_q      <= rp_next;
						ord_cnt_q <= ord_cnt_q - (TW + 1)'(1);
					end
					stk_cnt_q <= stk_cnt_q + (PW + 1)'(1);
					state_q   <= S_IDLE;
				end
				S_WIPE: begin
					wipe_idx_q <= wipe_idx_q + TW'(1);
					if (wipe_idx_q == TW'(NUM_TEAMS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Held command fields, fresh slot and result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			elem_q <= cmd.elem;
			team_q <= cmd.team;
			slot_q <= fresh_q[PW-1:0];
			rsp_q  <= '{element_out: '0,
				status: (cmd.op == OP_ENQUEUE) ? ST_FULL : ST_EMPTY};
		end
		if (state_q == S_DEQ_T) begin
			team_q <= ord_rd_q;
		end
		if (state_q == S_DEQ_W) begin
			rsp_q <= '{element_out: val_rd_q, status: ST_OK};
		end
	end

	// Team table: head, tail and waiting flag of each team.
	always_ff @(posedge clk) begin
		if (state_q == S_WIPE) begin
			team_mem[team_addr] <= '0;
		end else if (state_q == S_ENQ) begin
			team_mem[team_addr] <= waiting ? {1'b1, head, slot} : {1'b1, slot, slot};
		end else if (state_q == S_DEQ_W) begin
			team_mem[team_addr] <= (head == tail) ? {1'b0, head, tail}
				: {1'b1, nxt_rd_q, tail};
		end else if (pop || state_q == S_DEQ_T) begin
			team_rd_q <= team_mem[team_addr];
		end
	end

	// Team order queue.
	always_ff @(posedge clk) begin
		if (state_q == S_ENQ) begin
			if (!waiting) begin
				ord_mem[wp_q] <= team_q;
			end
		end else if (pop) begin
			ord_rd_q <= ord_mem[rp_q];
		end
	end

	// Free slot stack.
	always_ff @(posedge clk) begin
		if (state_q == S_DEQ_W) begin
			stk_mem[stk_cnt_q[PW-1:0]] <= head;
		end else if (pop) begin
			stk_rd_q <= stk_mem[stk_cnt_q[PW-1:0] - PW'(1)];
		end
	end

	// Pool element values.
	always_ff @(posedge clk) begin
		if (state_q == S_ENQ) begin
			val_mem[slot] <= elem_q;
		end else if (state_q == S_DEQ_E) begin
			val_rd_q <= val_mem[head];
		end
	end

	// Pool links to the next member of the same team.
	always_ff @(posedge clk) begin
		if (state_q == S_ENQ) begin
			if (waiting) begin
				nxt_mem[tail] <= slot;
			end
		end else if (state_q == S_DEQ_E) begin
			nxt_rd_q <= nxt_mem[head];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Every stacked slot was once handed out fresh.
	`TGF_ASSERT_IMP(a_stack_bound, clk, arst_n, 1'b1, stk_cnt_q <= fresh_q,
		"free stack holds more slots than were allocated")
	`TGF_ASSERT_IMP(a_order_bound, clk, arst_n, 1'b1, ord_cnt_q <= (TW + 1)'(NUM_TEAMS),
		"team order count exceeds the number of teams")
	`TGF_ASSERT_IMP(a_deq_nonempty, clk, arst_n, state_q == S_DEQ_W, ord_cnt_q != '0,
		"dequeue completes with an empty team order")
	`TGF_ASSERT_NXT(a_clear_resets, clk, arst_n, pop && cmd.op == OP_CLEAR,
		state_q == S_WIPE && fresh_q == '0 && ord_cnt_q == '0,
		"clear did not empty the pool and team order")

endmodule

FILE: design/team_grouped_fifo.sv
// ----------------------------------------------------------------------------
// Team grouped FIFO
// Team queue: elements of one team wait together, teams are served in
// order of arrival, and a dequeue takes the head member of the front team.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_ready  | operation, element_id, team_id
//   rsp     | out       | rsp_valid/rsp_ready  | element_out, status
//
// The front takes one word per cycle unless it is sweeping or its command
// stage is held by a full queue; assign words finish there. The back runs
// an enqueue through S_ENQ and a dequeue through S_DEQ_T, S_DEQ_E, S_DEQ_W,
// set by the chain of single-port reads through team order, team table and
// pool; a full or empty outcome comes straight from idle. Reset and every
// clear sweep the whole team table, reset also the membership table. A
// stalled result holds only the back; the front keeps filling the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module team_grouped_fifo
	import tgf_pkg::*;
#(
	parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF,
	parameter int NUM_TEAMS    = NUM_TEAMS_DEF,
	parameter int POOL_DEPTH   = POOL_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_word_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_word_t rsp
);

	logic fc_valid;
	logic fc_ready;
	cmd_t fc_cmd;
	logic cb_valid;
	logic cb_ready;
	cmd_t cb_cmd;

	// Front: membership table and classification.
	tgf_front #(
		.NUM_ELEMENTS(NUM_ELEMENTS),
		.NUM_TEAMS   (NUM_TEAMS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.cmd_valid(fc_valid),
		.cmd_ready(fc_ready),
		.cmd      (fc_cmd)
	);

	// Command queue between the two halves.
	tgf_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(fc_valid),
		.wr_ready(fc_ready),
		.wr_data (fc_cmd),
		.rd_valid(cb_valid),
		.rd_ready(cb_ready),
		.rd_data (cb_cmd)
	);

	// Back: linked pool, team table and team order.
	tgf_back #(
		.NUM_TEAMS (NUM_TEAMS),
		.POOL_DEPTH(POOL_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cb_valid),
		.cmd_ready(cb_ready),
		.cmd      (cb_cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule
